/* hdl/oust_pkg.sv */
// Shared types and constants for the ordered unique set table.
`timescale 1ns / 1ps

package oust_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CFG_W    = 1;

	localparam logic [CFG_W-1:0] CFG_LOWER = 1'b0;
	localparam logic [CFG_W-1:0] CFG_UPPER = 1'b1;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CHECK  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_RANGE     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BAD_INDEX = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              present;
		logic [DATA_W-1:0] entry_value;
		logic [CNT_W-1:0]  entry_count;
		status_t           status;
	} result_t;

endpackage

/* hdl/oust_core.sv */
// Sequencer and value memory: scan, append, shift-down remove and indexed read.
`timescale 1ns / 1ps

module oust_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   action,
	input  logic [oust_pkg::DATA_W-1:0]  item_value,
	input  logic [oust_pkg::IDX_W-1:0]   entry_index,
	input  logic [oust_pkg::DATA_W-1:0]  lower_q,
	input  logic [oust_pkg::DATA_W-1:0]  upper_q,
	output logic                         idle,
	output logic                         res_valid,
	input  logic                         res_take,
	output oust_pkg::result_t            res
);
	import oust_pkg::*;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	state_t            state_q, state_d;
	action_t           act_q;
	logic [DATA_W-1:0] val_q;
	logic              range_ok_q;
	logic [IDX_W-1:0]  addr_q, addr_d;
	logic [CNT_W-1:0]  count_q, count_d;
	result_t           res_q, res_d;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [CNT_W-1:0]  next_pos;
	logic              in_use;
	logic              hit;
	logic              last;

	// next_pos is one past the entry whose data sits in rdata_q
	assign next_pos = {1'b0, addr_q} + CNT_W'(1);
	assign in_use   = {1'b0, addr_q} < count_q;
	assign hit      = in_use && (rdata_q == val_q);
	assign last     = next_pos >= count_q;

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		count_d   = count_q;
		res_d     = res_q;
		we        = 1'b0;
		waddr     = addr_q;
		wdata     = rdata_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (accept) begin
					if (action_t'(action) == ACT_READ) begin
						if ({1'b0, entry_index} < count_q) begin
							addr_d  = entry_index;
							state_d = S_READ;
						end else begin
							res_d   = '{1'b0, '0, count_q, ST_BAD_INDEX};
							state_d = S_DONE;
						end
					end else begin
						addr_d  = '0;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit && act_q == ACT_REMOVE) begin
					if (!last) begin
						addr_d  = next_pos[IDX_W-1:0];
						state_d = S_SHIFT;
					end else begin
						count_d = count_q - CNT_W'(1);
						res_d   = '{1'b1, '0, count_d, ST_DONE};
						state_d = S_DONE;
					end
				end else if (hit || last) begin
					res_d.present     = hit;
					res_d.entry_value = '0;
					res_d.status      = ST_DONE;
					case (act_q)
						ACT_ADD: begin
							if (!range_ok_q) begin
								res_d.status = ST_RANGE;
							end else if (hit) begin
								res_d.status = ST_PRESENT;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								res_d.status = ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = count_q[IDX_W-1:0];
								wdata   = val_q;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_CHECK: begin
							if (!hit) res_d.status = ST_NOT_FOUND;
						end
						default: begin
							res_d.status = ST_NOT_FOUND;
						end
					endcase
					res_d.entry_count = count_d;
					state_d           = S_DONE;
				end else begin
					addr_d = next_pos[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				// entry addr_q moves down to addr_q - 1
				we    = 1'b1;
				waddr = addr_q - IDX_W'(1);
				wdata = rdata_q;
				if (!last) begin
					addr_d = next_pos[IDX_W-1:0];
				end else begin
					count_d = count_q - CNT_W'(1);
					res_d   = '{1'b1, '0, count_d, ST_DONE};
					state_d = S_DONE;
				end
			end
			S_READ: begin
				res_d   = '{1'b0, rdata_q, count_q, ST_DONE};
				state_d = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		res_q  <= res_d;
		if (state_q == S_IDLE && accept) begin
			act_q      <= action_t'(action);
			val_q      <= item_value;
			range_ok_q <= (item_value >= lower_q) && (item_value < upper_q);
		end
	end

	// single-port style memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[addr_d];
	end

	assign res = res_q;

endmodule

/* hdl/ordered_unique_set_table.sv */
// A read fetches the entry through the registered memory port (a bad index goes straight to
// the result); add/check/remove scan the entries from index 0 until a hit or the last one.
// Throughput: one item at a time, bounded by the single memory read port that scans
// entries and then shifts them down on a remove.
// A result waiting in the output register does not block the next item.
// Reset clears count and handshake state, sets bounds to 0 and all ones; store contents are kept.
`timescale 1ns / 1ps

module ordered_unique_set_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [oust_pkg::CFG_W-1:0]   cfg_index,
	input  logic [oust_pkg::DATA_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [oust_pkg::DATA_W-1:0]  item_value,
	input  logic [oust_pkg::IDX_W-1:0]   entry_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         present,
	output logic [oust_pkg::DATA_W-1:0]  entry_value,
	output logic [oust_pkg::CNT_W-1:0]   entry_count,
	output logic [2:0]                   status
);
	import oust_pkg::*;

	logic [DATA_W-1:0] lower_q, upper_q;
	logic              core_idle;
	logic              res_valid;
	logic              res_take;
	logic              out_valid_q;
	result_t           res;
	result_t           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER: lower_q <= cfg_wdata;
				CFG_UPPER: upper_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = !core_idle;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	oust_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_valid && !in_stall),
		.action      (action),
		.item_value  (item_value),
		.entry_index (entry_index),
		.lower_q     (lower_q),
		.upper_q     (upper_q),
		.idle        (core_idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign present     = out_q.present;
	assign entry_value = out_q.entry_value;
	assign entry_count = out_q.entry_count;
	assign status      = out_q.status;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("entry_count beyond capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled while an item is in work");

	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BAD_INDEX) |-> (entry_value == '0 && !present))
		else $error("bad index beat carries data");

	a_dup_present: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_PRESENT) |-> present)
		else $error("already-present status without present flag");

endmodule
